/* sv/dse_pkg.sv */
// shared constants and types of the decision stump edge search
`timescale 1ns / 1ps

package dse_pkg;

    // field widths of the input and result beats
    localparam int OP_W   = 2;
    localparam int FEAT_W = 6;
    localparam int VAL_W  = 32;
    localparam int WGT_W  = 32;
    localparam int LBL_W  = 8;
    localparam int CUT_W  = 33;

    // signed Q12.32 edge, saturating
    localparam int EDGE_W = 44;

    // samples of features at or above this index are dropped
    localparam int unsigned MAX_FEATURES = 64;

    // default depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ACCUM  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    // classified command, front to back
    typedef struct packed {
        t_op                     op;
        logic [FEAT_W-1:0]       feat;
        logic signed [VAL_W-1:0] value;
        logic [WGT_W-1:0]        weight;
        logic                    positive;
        logic                    first;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic pop;
        logic fin_fire;
    } t_back_status;

endpackage

/* sv/dse_if.sv */
// handshake channels of the decision stump edge search
`timescale 1ns / 1ps

interface dse_in_if;
    logic                              valid;
    logic                              ready;
    logic [dse_pkg::OP_W-1:0]          op;
    logic [dse_pkg::FEAT_W-1:0]        feature_index;
    logic signed [dse_pkg::VAL_W-1:0]  feature_value;
    logic [dse_pkg::WGT_W-1:0]         sample_weight;
    logic [dse_pkg::LBL_W-1:0]         sample_label;
    logic                              first_of_feature;

    modport source (
        output valid, op, feature_index, feature_value, sample_weight, sample_label,
               first_of_feature,
        input  ready
    );
    modport sink (
        input  valid, op, feature_index, feature_value, sample_weight, sample_label,
               first_of_feature,
        output ready
    );
endinterface

interface dse_out_if;
    logic                              valid;
    logic                              ready;
    logic [dse_pkg::FEAT_W-1:0]        chosen_feature;
    logic signed [dse_pkg::CUT_W-1:0]  cut_twice;
    logic                              low_side_pos;
    logic                              constant_stump;

    modport source (
        output valid, chosen_feature, cut_twice, low_side_pos, constant_stump,
        input  ready
    );
    modport sink (
        input  valid, chosen_feature, cut_twice, low_side_pos, constant_stump,
        output ready
    );
endinterface

interface dse_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dse_pkg::LBL_W-1:0]  target_label;

    modport source (output valid, target_label, input ready);
    modport sink (input valid, target_label, output ready);
endinterface

/* sv/dse_front.sv */
// input handshake, target label register and command classification
`timescale 1ns / 1ps

module dse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dse_cfg_if.sink       i_cfg,
    dse_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output dse_pkg::t_cmd o_cmd
);
    import dse_pkg::*;

    logic [LBL_W-1:0] r_target_label;
    logic             w_beat;
    logic             w_keep;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_label <= '0;
        end else if (i_cfg.valid) begin
            r_target_label <= i_cfg.target_label;
        end
    end

    assign i_in.ready = !i_q_full;
    assign w_beat     = i_in.valid && i_in.ready;

    // unused op and out of range features are taken and dropped
    always_comb begin
        w_keep = 1'b0;
        unique case (i_in.op)
            OP_ACCUM, OP_FINISH: w_keep = 1'b1;
            OP_SAMPLE:           w_keep = (32'(i_in.feature_index) < MAX_FEATURES);
            default:             w_keep = 1'b0;
        endcase
    end

    assign o_push = w_beat && w_keep;

    always_comb begin
        o_cmd.op       = t_op'(i_in.op);
        o_cmd.feat     = i_in.feature_index;
        o_cmd.value    = i_in.feature_value;
        o_cmd.weight   = i_in.sample_weight;
        o_cmd.positive = (i_in.sample_label == r_target_label);
        o_cmd.first    = i_in.first_of_feature;
    end

endmodule

/* sv/dse_queue.sv */
// small command queue between front and back
`timescale 1ns / 1ps

module dse_queue #(
    parameter int unsigned DEPTH = dse_pkg::QUEUE_DEPTH  // at least 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dse_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output dse_pkg::t_cmd      o_cmd,
    output dse_pkg::t_q_status o_status
);
    import dse_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

/* sv/dse_back.sv */
// edge update, best cut tracking and result register
`timescale 1ns / 1ps

module dse_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  dse_pkg::t_cmd         i_cmd,
    output dse_pkg::t_back_status o_status,
    dse_out_if.source             o_out
);
    import dse_pkg::*;

    function automatic logic signed [EDGE_W-1:0] sat_edge(input logic signed [EDGE_W:0] x);
        logic signed [EDGE_W-1:0] y;
        if (x[EDGE_W] != x[EDGE_W-1]) begin
            y = x[EDGE_W] ? {1'b1, {(EDGE_W-1){1'b0}}} : {1'b0, {(EDGE_W-1){1'b1}}};
        end else begin
            y = x[EDGE_W-1:0];
        end
        return y;
    endfunction

    // edge stage state
    logic signed [EDGE_W-1:0] r_total,      n_total;
    logic signed [EDGE_W-1:0] r_running,    n_running;
    logic signed [VAL_W-1:0]  r_prev_value, n_prev_value;
    logic [WGT_W-1:0]         r_prev_weight, n_prev_weight;
    logic                     r_prev_pos,   n_prev_pos;

    // candidate / finish stage
    logic                     r_s_valid, n_s_valid;
    logic                     r_s_fin,   n_s_fin;
    logic signed [EDGE_W-1:0] r_s_edge,  n_s_edge;
    logic [FEAT_W-1:0]        r_s_feat,  n_s_feat;
    logic signed [CUT_W-1:0]  r_s_cut,   n_s_cut;

    // best cut so far
    logic [EDGE_W-1:0]        r_best_mag,  n_best_mag;
    logic                     r_best_neg,  n_best_neg;
    logic [FEAT_W-1:0]        r_best_feat, n_best_feat;
    logic signed [CUT_W-1:0]  r_best_cut,  n_best_cut;

    // result register
    logic                     r_out_valid, n_out_valid;
    logic [FEAT_W-1:0]        r_o_feat,    n_o_feat;
    logic signed [CUT_W-1:0]  r_o_cut,     n_o_cut;
    logic                     r_o_left,    n_o_left;
    logic                     r_o_const,   n_o_const;

    logic                     w_adv;
    logic                     w_pop;
    logic                     w_fin_fire;
    logic signed [EDGE_W:0]   w_tot_wide;
    logic signed [EDGE_W:0]   w_run_wide;
    logic [EDGE_W:0]          w_wgt_ext;
    logic [EDGE_W:0]          w_twice;
    logic signed [EDGE_W-1:0] w_run_sat;
    logic [EDGE_W-1:0]        w_s_mag;
    logic                     w_const;

    // a finish waits only while the result register is still full
    assign w_adv      = !r_s_valid || !r_s_fin || !r_out_valid || o_out.ready;
    assign w_pop      = !i_q_empty && w_adv;
    assign w_fin_fire = w_adv && r_s_valid && r_s_fin;

    assign w_wgt_ext  = {{(EDGE_W + 1 - WGT_W){1'b0}}, i_cmd.weight};
    assign w_twice    = {{(EDGE_W - WGT_W){1'b0}}, r_prev_weight, 1'b0};
    assign w_tot_wide = i_cmd.positive ? {r_total[EDGE_W-1], r_total} + w_wgt_ext
                                       : {r_total[EDGE_W-1], r_total} - w_wgt_ext;
    assign w_run_wide = r_prev_pos ? {r_running[EDGE_W-1], r_running} - w_twice
                                   : {r_running[EDGE_W-1], r_running} + w_twice;
    assign w_run_sat  = sat_edge(w_run_wide);

    assign w_s_mag = r_s_edge[EDGE_W-1] ? EDGE_W'(unsigned'(-r_s_edge))
                                        : EDGE_W'(unsigned'(r_s_edge));
    assign w_const = (w_s_mag >= r_best_mag);

    always_comb begin
        n_total       = r_total;
        n_running     = r_running;
        n_prev_value  = r_prev_value;
        n_prev_weight = r_prev_weight;
        n_prev_pos    = r_prev_pos;
        n_s_valid     = r_s_valid;
        n_s_fin       = r_s_fin;
        n_s_edge      = r_s_edge;
        n_s_feat      = r_s_feat;
        n_s_cut       = r_s_cut;
        n_best_mag    = r_best_mag;
        n_best_neg    = r_best_neg;
        n_best_feat   = r_best_feat;
        n_best_cut    = r_best_cut;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_o_feat      = r_o_feat;
        n_o_cut       = r_o_cut;
        n_o_left      = r_o_left;
        n_o_const     = r_o_const;

        // best stage: retire what sits in the candidate register
        if (w_adv && r_s_valid) begin
            if (r_s_fin) begin
                n_out_valid = 1'b1;
                n_o_const   = w_const;
                n_o_feat    = w_const ? '0 : r_best_feat;
                n_o_cut     = w_const ? '0 : r_best_cut;
                n_o_left    = w_const ? r_s_edge[EDGE_W-1] : r_best_neg;
                n_best_mag  = '0;
                n_best_neg  = 1'b0;
                n_best_feat = '0;
                n_best_cut  = '0;
            end else if (w_s_mag > r_best_mag) begin
                n_best_mag  = w_s_mag;
                n_best_neg  = r_s_edge[EDGE_W-1];
                n_best_feat = r_s_feat;
                n_best_cut  = r_s_cut;
            end
        end

        // edge stage: execute the queue head
        if (w_adv) begin
            n_s_valid = 1'b0;
            if (w_pop) begin
                unique case (i_cmd.op)
                    OP_ACCUM: begin
                        n_total = sat_edge(w_tot_wide);
                    end
                    OP_SAMPLE: begin
                        if (i_cmd.first) begin
                            n_running = r_total;
                        end else begin
                            n_running = w_run_sat;
                            if (i_cmd.value != r_prev_value) begin
                                n_s_valid = 1'b1;
                                n_s_fin   = 1'b0;
                                n_s_edge  = w_run_sat;
                                n_s_feat  = i_cmd.feat;
                                n_s_cut   = {i_cmd.value[VAL_W-1], i_cmd.value}
                                          + {r_prev_value[VAL_W-1], r_prev_value};
                            end
                        end
                        n_prev_value  = i_cmd.value;
                        n_prev_weight = i_cmd.weight;
                        n_prev_pos    = i_cmd.positive;
                    end
                    OP_FINISH: begin
                        n_s_valid     = 1'b1;
                        n_s_fin       = 1'b1;
                        n_s_edge      = r_total;
                        n_total       = '0;
                        n_running     = '0;
                        n_prev_value  = '0;
                        n_prev_weight = '0;
                        n_prev_pos    = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total       <= '0;
            r_running     <= '0;
            r_prev_value  <= '0;
            r_prev_weight <= '0;
            r_prev_pos    <= 1'b0;
            r_s_valid     <= 1'b0;
            r_s_fin       <= 1'b0;
            r_best_mag    <= '0;
            r_best_neg    <= 1'b0;
            r_best_feat   <= '0;
            r_best_cut    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_total       <= n_total;
            r_running     <= n_running;
            r_prev_value  <= n_prev_value;
            r_prev_weight <= n_prev_weight;
            r_prev_pos    <= n_prev_pos;
            r_s_valid     <= n_s_valid;
            r_s_fin       <= n_s_fin;
            r_best_mag    <= n_best_mag;
            r_best_neg    <= n_best_neg;
            r_best_feat   <= n_best_feat;
            r_best_cut    <= n_best_cut;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_edge  <= n_s_edge;
        r_s_feat  <= n_s_feat;
        r_s_cut   <= n_s_cut;
        r_o_feat  <= n_o_feat;
        r_o_cut   <= n_o_cut;
        r_o_left  <= n_o_left;
        r_o_const <= n_o_const;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.chosen_feature = r_o_feat;
    assign o_out.cut_twice      = r_o_cut;
    assign o_out.low_side_pos   = r_o_left;
    assign o_out.constant_stump = r_o_const;

    assign o_status.pop      = w_pop;
    assign o_status.fin_fire = w_fin_fire;

endmodule

/* sv/decision_stump_edge_search.sv */
// top level of the weighted decision stump edge search
`timescale 1ns / 1ps

// Trains one weighted decision stump. Accumulate beats add each sample's signed weight
// (plus if its label matches target_label, minus otherwise) into the constant edge. Sample
// beats then stream every feature's samples in ascending value order, the first of each
// feature flagged; each later sample lowers the running edge by twice the previous sample's
// signed weight and, where the value changes, offers a cut that wins on a strictly larger
// absolute edge. A finish beat yields one result beat (the constant stump wins ties) and
// clears the search for the next round; target_label is kept. Edges are signed Q12.32 in
// 44 bits and saturate; cut_twice is the exact sum of the two values around the cut.
// Throughput is one input beat per clock: the front takes a beat whenever the command queue
// has room, and the back retires one command per clock while no finish waits, its running
// edge add and saturate feeding its register directly. A finish passes the queue, candidate
// register and result register before its result is valid; a result waiting at the output
// stalls only finish commands and the queue behind, so input stalls on a full queue alone.
module decision_stump_edge_search #(
    parameter int unsigned QUEUE_DEPTH = dse_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dse_cfg_if.sink   i_cfg,
    dse_in_if.sink    i_in,
    dse_out_if.source o_out
);
    import dse_pkg::*;

    logic         w_push;
    t_cmd         w_front_cmd;    // classified command into the queue
    t_cmd         w_head_cmd;     // queue head seen by the back
    t_q_status    w_q_stat;
    t_back_status w_b_stat;

    // front: config register, accept beats, drop what has no effect
    dse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_in     (i_in),
        .i_q_full (w_q_stat.full),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    // decoupling queue
    dse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_b_stat.pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_stat)
    );

    // back: edge arithmetic, best cut, result register
    dse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_stat.empty),
        .i_cmd     (w_head_cmd),
        .o_status  (w_b_stat),
        .o_out     (o_out)
    );

    // no push into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("push into full queue");

    // no pop from an empty queue
    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b_stat.pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    // a result appears only after a finish retired
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_b_stat.fin_fire))
        else $error("result without finish");

    // constant stump carries no feature and no cut
    a_const_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.constant_stump)
            |-> (o_out.chosen_feature == '0 && o_out.cut_twice == '0))
        else $error("constant stump with cut fields");

endmodule

/* sim/tb_top.sv */
// testbench of the decision stump edge search: random training rounds checked against a predictor
`timescale 1ns / 1ps

module tb_top;
    import dse_pkg::*;

    // run limit in clocks, far above the slowest legal run
    localparam int unsigned RUN_LIMIT = 400000;
    // clocks allowed for the pipeline to drain before a register write or the end
    localparam int unsigned DRAIN_CLKS = 16;
    // number of random items to aim for, random rounds only
    localparam int unsigned RANDOM_ITEMS = 420;
    // samples after the first in a saturation round, enough to drive the running edge past its bound
    localparam int unsigned SAT_SAMPLES = 1030;

    localparam longint EDGE_HI = 64'sd8796093022207;
    localparam longint EDGE_LO = -64'sd8796093022208;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [FEAT_W-1:0] feat;
        logic [VAL_W-1:0]  value;
        logic [WGT_W-1:0]  weight;
        logic [LBL_W-1:0]  label;
        logic              first;
    } t_sample_beat;

    typedef struct {
        logic [FEAT_W-1:0] feat;
        logic [CUT_W-1:0]  cut;
        logic              left_pos;
        logic              is_const;
    } t_stump;

    logic i_clk;
    logic i_rst_n;

    dse_in_if  in_if ();
    dse_out_if out_if ();
    dse_cfg_if cfg_if ();

    decision_stump_edge_search u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // beats waiting for the driver and stumps waiting for the output
    t_sample_beat beat_q[$];
    t_stump       stump_q[$];

    int unsigned err_cnt;
    int unsigned cycle_cnt;
    int unsigned item_cnt;
    int unsigned result_cnt;
    logic        in_taken;

    // predictor state, a mirror of the search registers
    logic [LBL_W-1:0]         tgt_label;
    logic signed [EDGE_W-1:0] tot_edge;
    logic signed [EDGE_W-1:0] run_edge;
    logic signed [EDGE_W-1:0] top_edge;
    logic [FEAT_W-1:0]        top_feat;
    logic [CUT_W-1:0]         top_cut;
    logic signed [VAL_W-1:0]  last_val;
    logic [WGT_W-1:0]         last_wgt;
    logic                     last_pos;

    task automatic flag_error(input string msg);
        $display("[tb] mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    function automatic logic signed [EDGE_W-1:0] sat_edge(input longint x);
        longint y;
        y = x;
        if (y > EDGE_HI) y = EDGE_HI;
        if (y < EDGE_LO) y = EDGE_LO;
        return y[EDGE_W-1:0];
    endfunction

    function automatic longint edge_mag(input logic signed [EDGE_W-1:0] e);
        longint v;
        v = e;
        return (v < 0) ? -v : v;
    endfunction

    task automatic clear_search();
        tot_edge = '0;
        run_edge = '0;
        top_edge = '0;
        top_feat = '0;
        top_cut  = '0;
        last_val = '0;
        last_wgt = '0;
        last_pos = 1'b0;
    endtask

    // advance the mirror by one accepted beat, queueing the stump a finish yields
    task automatic predict_stump(input t_sample_beat b);
        logic   pos;
        longint twice;
        longint cut_sum;
        t_stump res;
        pos = (b.label == tgt_label);
        case (b.op)
            OP_ACCUM: begin
                tot_edge = sat_edge(longint'(tot_edge) +
                                    (pos ? longint'(b.weight) : -longint'(b.weight)));
            end
            OP_SAMPLE: begin
                if (b.first) begin
                    run_edge = tot_edge;
                end else begin
                    twice = longint'(last_wgt) * 2;
                    run_edge = sat_edge(longint'(run_edge) - (last_pos ? twice : -twice));
                    // only a change of value can be a cut
                    if ($signed(b.value) != last_val && edge_mag(run_edge) > edge_mag(top_edge)) begin
                        cut_sum  = longint'($signed(b.value)) + longint'(last_val);
                        top_edge = run_edge;
                        top_feat = b.feat;
                        top_cut  = cut_sum[CUT_W-1:0];
                    end
                end
                last_val = b.value;
                last_wgt = b.weight;
                last_pos = pos;
            end
            OP_FINISH: begin
                // constant stump wins ties
                if (edge_mag(tot_edge) >= edge_mag(top_edge)) begin
                    res.feat     = '0;
                    res.cut      = '0;
                    res.left_pos = tot_edge < 0;
                    res.is_const = 1'b1;
                end else begin
                    res.feat     = top_feat;
                    res.cut      = top_cut;
                    res.left_pos = top_edge < 0;
                    res.is_const = 1'b0;
                end
                stump_q.push_back(res);
                clear_search();
            end
            default: begin
                // unused op, no effect
            end
        endcase
    endtask

    // monitor: output check and input prediction, all on the rising edge
    always @(posedge i_clk) begin : monitor
        t_stump       want;
        t_sample_beat seen;
        cycle_cnt++;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("[tb] run limit reached, %0d stumps outstanding", stump_q.size());
            $display("[decision_stump_edge_search] ERROR");
            $finish;
        end else begin
            in_taken = 1'b0;
            if (i_rst_n) begin
                // result beat first, a finish taken now cannot show up this soon
                if (out_if.valid && out_if.ready) begin
                    if (stump_q.size() == 0) begin
                        flag_error($sformatf("result with nothing expected, feature %0d",
                                             out_if.chosen_feature));
                    end else begin
                        want = stump_q.pop_front();
                        if (out_if.chosen_feature !== want.feat)
                            flag_error($sformatf("result %0d chosen_feature %0d want %0d",
                                                 result_cnt, out_if.chosen_feature, want.feat));
                        if (out_if.cut_twice !== want.cut)
                            flag_error($sformatf("result %0d cut_twice %h want %h",
                                                 result_cnt, out_if.cut_twice, want.cut));
                        if (out_if.low_side_pos !== want.left_pos)
                            flag_error($sformatf("result %0d low_side_pos %b want %b",
                                                 result_cnt, out_if.low_side_pos,
                                                 want.left_pos));
                        if (out_if.constant_stump !== want.is_const)
                            flag_error($sformatf("result %0d constant_stump %b want %b",
                                                 result_cnt, out_if.constant_stump,
                                                 want.is_const));
                    end
                    result_cnt++;
                end
                if (in_if.valid && in_if.ready) begin
                    in_taken     = 1'b1;
                    seen.op      = in_if.op;
                    seen.feat    = in_if.feature_index;
                    seen.value   = in_if.feature_value;
                    seen.weight  = in_if.sample_weight;
                    seen.label   = in_if.sample_label;
                    seen.first   = in_if.first_of_feature;
                    predict_stump(seen);
                end
            end
        end
    end

    // driver: bursts of beats with random gaps, new beat only once the last one is taken
    int unsigned burst_left;
    int unsigned gap_left;

    always @(negedge i_clk) begin : driver
        t_sample_beat b;
        if (!in_if.valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (beat_q.size() != 0) begin
                b = beat_q.pop_front();
                in_if.op               <= b.op;
                in_if.feature_index    <= b.feat;
                in_if.feature_value    <= b.value;
                in_if.sample_weight    <= b.weight;
                in_if.sample_label     <= b.label;
                in_if.first_of_feature <= b.first;
                in_if.valid            <= 1'b1;
                if (burst_left <= 1) begin
                    // now and then a long stretch with no gaps at all
                    if ($urandom_range(0, 15) == 0) begin
                        burst_left = 300;
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    burst_left--;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver: one of three modes, picked anew at random:
    // free running, coin flip, or long stalls with single ready clocks
    int unsigned rx_mode;
    int unsigned mode_left;
    int unsigned hold_left;

    always @(negedge i_clk) begin : receiver
        if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 2);
            mode_left = $urandom_range(32, 400);
        end else begin
            mode_left--;
        end
        case (rx_mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= 1'($urandom_range(0, 1));
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    out_if.ready <= 1'b0;
                end else begin
                    out_if.ready <= 1'b1;
                    hold_left = $urandom_range(1, 25);
                end
            end
        endcase
    end

    task automatic push_beat(input logic [OP_W-1:0] op, input logic [FEAT_W-1:0] feat,
                             input logic [VAL_W-1:0] value, input logic [WGT_W-1:0] weight,
                             input logic [LBL_W-1:0] label, input logic first);
        t_sample_beat b;
        b.op     = op;
        b.feat   = feat;
        b.value  = value;
        b.weight = weight;
        b.label  = label;
        b.first  = first;
        beat_q.push_back(b);
        if (op != OP_UNUSED) item_cnt++;
    endtask

    // block idle: nothing queued, nothing on the wire, no stump outstanding, pipe drained
    task automatic wait_drained();
        while (beat_q.size() != 0 || in_if.valid || stump_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CLKS) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [LBL_W-1:0] lbl);
        @(negedge i_clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.target_label <= lbl;
        do @(posedge i_clk); while (!cfg_if.ready);
        tgt_label = lbl;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [WGT_W-1:0] pick_weight();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1000);
            1: return $urandom;
            2: return '1;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // half the labels match the target, the rest are anything
    function automatic logic [LBL_W-1:0] pick_label();
        return $urandom_range(0, 1) ? tgt_label : LBL_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [LBL_W-1:0] other_label();
        return tgt_label + LBL_W'($urandom_range(1, 255));
    endfunction

    // one well-formed round: accumulate the sample set, then stream it sorted per feature
    task automatic train_round();
        int               n;
        int               nf;
        int               i;
        int               j;
        int               k;
        int               tmp;
        int               perm[12];
        logic [WGT_W-1:0] wgt[12];
        logic [LBL_W-1:0] lbl[12];
        logic [FEAT_W-1:0] f;
        logic             fst;
        longint           v;
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) begin
            wgt[i] = pick_weight();
            lbl[i] = pick_label();
            push_beat(OP_ACCUM, FEAT_W'($urandom), $urandom, wgt[i], lbl[i],
                      1'($urandom_range(0, 1)));
        end
        nf = $urandom_range(1, 3);
        for (k = 0; k < nf; k++) begin
            f = FEAT_W'($urandom);
            for (i = 0; i < n; i++) perm[i] = i;
            for (i = n - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            case ($urandom_range(0, 3))
                0: v = -64'sd2147483648;
                1: v = longint'($signed($urandom));
                2: v = longint'($urandom_range(0, 32'h40000)) - 64'sd131072;
                default: v = 64'sd2147483647 - longint'($urandom_range(0, 32'h100000));
            endcase
            for (i = 0; i < n; i++) begin
                if (i > 0) begin
                    // ascending with duplicates, small steps and big jumps
                    case ($urandom_range(0, 3))
                        0: v = v;
                        1: v = v + longint'($urandom_range(1, 32'h30000));
                        2: v = v + longint'($urandom);
                        default: v = v + 1;
                    endcase
                    if (v > 64'sd2147483647) v = 64'sd2147483647;
                end
                // occasional stray unused op, missing or extra first flag
                if ($urandom_range(0, 24) == 0)
                    push_beat(OP_UNUSED, FEAT_W'($urandom), $urandom, $urandom,
                              LBL_W'($urandom), 1'b1);
                if (i == 0) fst = ($urandom_range(0, 9) != 0);
                else        fst = ($urandom_range(0, 29) == 0);
                push_beat(OP_SAMPLE, f, v[VAL_W-1:0], wgt[perm[i]], lbl[perm[i]], fst);
            end
        end
        push_beat(OP_FINISH, FEAT_W'($urandom), $urandom, $urandom, LBL_W'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    // loose beats of any op, then a finish
    task automatic noise_round();
        int n;
        int i;
        n = $urandom_range(1, 16);
        for (i = 0; i < n; i++)
            push_beat(OP_W'($urandom_range(0, 3)), FEAT_W'($urandom), $urandom, pick_weight(),
                      pick_label(), 1'($urandom_range(0, 1)));
        push_beat(OP_FINISH, FEAT_W'($urandom), $urandom, $urandom, LBL_W'($urandom),
                  1'($urandom_range(0, 1)));
    endtask

    // full weights of one sign until the running edge saturates
    task automatic saturate_round(input logic pos);
        int                unsigned i;
        logic [FEAT_W-1:0] f;
        logic [LBL_W-1:0]  l;
        logic [VAL_W-1:0]  v;
        f = FEAT_W'($urandom);
        l = pos ? tgt_label : other_label();
        v = 32'h8000_0000;
        push_beat(OP_SAMPLE, f, v, '1, l, 1'b1);
        for (i = 1; i <= SAT_SAMPLES; i++) begin
            v = v + 32'h0001_0000;
            push_beat(OP_SAMPLE, f, v, '1, l, 1'b0);
        end
        push_beat(OP_FINISH, '0, '0, '0, '0, 1'b0);
    endtask

    initial begin : stimulus
        int unsigned rand_end;
        // every input known from time zero
        i_rst_n                = 1'b0;
        in_if.valid            = 1'b0;
        in_if.op               = '0;
        in_if.feature_index    = '0;
        in_if.feature_value    = '0;
        in_if.sample_weight    = '0;
        in_if.sample_label     = '0;
        in_if.first_of_feature = 1'b0;
        out_if.ready           = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.target_label    = '0;
        err_cnt    = 0;
        cycle_cnt  = 0;
        item_cnt   = 0;
        result_cnt = 0;
        in_taken   = 1'b0;
        burst_left = 0;
        gap_left   = 0;
        rx_mode    = 0;
        mode_left  = 0;
        hold_left  = 0;
        tgt_label  = '0;
        clear_search();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_target(8'd0);

        // finish straight after reset, constant stump on a zero edge
        push_beat(OP_FINISH, '0, '0, '0, '0, 1'b0);
        // accumulate extremes, other fields ignored
        push_beat(OP_ACCUM, 6'h3F, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b1);
        push_beat(OP_ACCUM, 6'h00, 32'h0000_0000, 32'h0000_0000, 8'hFF, 1'b0);
        push_beat(OP_ACCUM, 6'h00, 32'h8000_0000, 32'd5, 8'h07, 1'b1);
        // unused op with every bit set
        push_beat(OP_UNUSED, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        // sample with no first flag before it, runs on the cleared state
        push_beat(OP_SAMPLE, 6'h3F, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0);
        push_beat(OP_SAMPLE, 6'h00, 32'h8000_0000, 32'd1, 8'h01, 1'b1);
        // repeated value is no cut
        push_beat(OP_SAMPLE, 6'h00, 32'h8000_0000, 32'd2, 8'h00, 1'b0);
        push_beat(OP_SAMPLE, 6'h00, 32'h0000_0000, 32'hFFFF_FFFF, 8'h01, 1'b0);
        push_beat(OP_SAMPLE, 6'h00, 32'h7FFF_FFFF, 32'h0000_0000, 8'h00, 1'b0);
        push_beat(OP_FINISH, 6'h15, 32'h1234_5678, 32'h9ABC_DEF0, 8'h55, 1'b1);
        // tie between constant stump and best cut, constant wins
        push_beat(OP_ACCUM, 6'h00, 32'h0, 32'd100, 8'h00, 1'b0);
        push_beat(OP_SAMPLE, 6'h09, 32'd1, 32'd100, 8'h00, 1'b1);
        push_beat(OP_SAMPLE, 6'h09, 32'd2, 32'd7, 8'h03, 1'b0);
        push_beat(OP_FINISH, '0, '0, '0, '0, 1'b0);
        // negative best cut beats a negative total
        push_beat(OP_ACCUM, 6'h00, 32'h0, 32'd1000, 8'h09, 1'b0);
        push_beat(OP_SAMPLE, 6'h28, -32'sd5, 32'd10, 8'h00, 1'b1);
        push_beat(OP_SAMPLE, 6'h28, 32'd3, 32'd1, 8'h02, 1'b0);
        push_beat(OP_FINISH, '0, '0, '0, '0, 1'b0);
        // constant stump on a negative total
        push_beat(OP_ACCUM, 6'h00, 32'h0, 32'd50, 8'h04, 1'b0);
        push_beat(OP_FINISH, '0, '0, '0, '0, 1'b0);
        // cut at the top of the value range
        push_beat(OP_SAMPLE, 6'h3F, 32'h7FFF_FFFE, 32'd3, 8'h00, 1'b1);
        push_beat(OP_SAMPLE, 6'h3F, 32'h7FFF_FFFF, 32'd0, 8'h00, 1'b0);
        push_beat(OP_FINISH, '0, '0, '0, '0, 1'b0);

        wait_drained();
        write_target(8'hFF);

        // random rounds, mostly well formed, target label moved between some of them
        rand_end = item_cnt + RANDOM_ITEMS;
        while (item_cnt < rand_end) begin
            if ($urandom_range(0, 5) == 0) begin
                wait_drained();
                case ($urandom_range(0, 2))
                    0: write_target(8'h00);
                    1: write_target(8'hFF);
                    default: write_target(LBL_W'($urandom));
                endcase
            end
            if ($urandom_range(0, 7) == 0) noise_round();
            else                          train_round();
        end

        // running edge saturation at one bound, picked at random
        wait_drained();
        write_target(LBL_W'($urandom));
        saturate_round(1'($urandom_range(0, 1)));
        train_round();

        wait_drained();
        if (stump_q.size() != 0)
            flag_error($sformatf("%0d stumps never arrived", stump_q.size()));
        if (err_cnt == 0) begin
            $display("[decision_stump_edge_search] OK");
        end else begin
            $display("[decision_stump_edge_search] ERROR");
        end
        $finish;
    end

endmodule
